FILE: rtl/tld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tld_pkg: shared types and constants
// Operation and status codes, ring geometry and sequencer states.
// ----------------------------------------------------------------------------
package tld_pkg;
  localparam int unsigned RingDepth = 256;
  localparam int unsigned MaxRead   = 64;
  localparam int unsigned PtrW      = $clog2(RingDepth);
  localparam int unsigned FillW     = $clog2(RingDepth + 1);

  localparam logic [2:0] OpMasterWrite = 3'd0;
  localparam logic [2:0] OpMasterRead  = 3'd1;
  localparam logic [2:0] OpSlaveWrite  = 3'd2;
  localparam logic [2:0] OpSlaveRead   = 3'd3;
  localparam logic [2:0] OpCloseMaster = 3'd4;
  localparam logic [2:0] OpCloseSlave  = 3'd5;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StClosed  = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StNotRdy  = 3'd3;
  localparam logic [2:0] StEof     = 3'd4;

  localparam logic [1:0] SigNone = 2'd0;
  localparam logic [1:0] SigInt  = 2'd1;
  localparam logic [1:0] SigStop = 2'd2;

  localparam logic [1:0] CfgEcho  = 2'd0;
  localparam logic [1:0] CfgCanon = 2'd1;
  localparam logic [1:0] CfgGroup = 2'd2;

  localparam logic [7:0] ChIntr = 8'h03;
  localparam logic [7:0] ChEof  = 8'h04;
  localparam logic [7:0] ChKill = 8'h15;
  localparam logic [7:0] ChSusp = 8'h1A;
  localparam logic [7:0] ChDel  = 8'h7F;
  localparam logic [7:0] ChBs   = 8'h08;
  localparam logic [7:0] ChNl   = 8'h0A;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChC    = 8'h43;
  localparam logic [7:0] ChZ    = 8'h5A;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ECHO, S_ERASE_RD, S_ERASE_CHK, S_IRD, S_ORD,
    S_RDWAIT, S_EMIT, S_DONE
  } state_e;

  // Request from the sequencer to the ring unit for one access
  typedef struct packed {
    logic             in_we;
    logic [PtrW-1:0]  in_waddr;
    logic [7:0]       in_wdata;
    logic             in_re;
    logic [PtrW-1:0]  in_raddr;
    logic             out_we;
    logic [PtrW-1:0]  out_waddr;
    logic [7:0]       out_wdata;
    logic             out_re;
    logic [PtrW-1:0]  out_raddr;
  } ring_req_t;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(RingDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
    ptr_dec = (p == '0) ? PtrW'(RingDepth - 1) : p - 1'b1;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/tld_rings.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tld_rings: input and output byte rings
// Two single-port-write, single-read memories with registered read data.
// ----------------------------------------------------------------------------
module tld_rings (
  input  wire logic              clk_i,
  input  wire tld_pkg::ring_req_t req_i,
  output logic [7:0]             in_rdata_o,
  output logic [7:0]             out_rdata_o
);
  logic [7:0] in_mem  [tld_pkg::RingDepth];
  logic [7:0] out_mem [tld_pkg::RingDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.in_we) in_mem[req_i.in_waddr] <= req_i.in_wdata;
    if (req_i.in_re) in_rdata_o <= in_mem[req_i.in_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.out_we) out_mem[req_i.out_waddr] <= req_i.out_wdata;
    if (req_i.out_re) out_rdata_o <= out_mem[req_i.out_raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/terminal_line_discipline_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_line_discipline_top: pseudo-terminal line discipline
// One sequencer drives two byte rings through single ring accesses.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (operation, data_byte, read_length) are taken on
//   in_valid_i & in_ready_o. Each beat yields one or more result beats on
//   out_valid_o & out_ready_i; last_of_run_o marks the final one.
//   Config writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at once;
//   issue them only while the block is idle; the block does not enforce it.
// Sequencing:
//   The sequencer handles one item at a time and in_ready_o is low until its
//   final result beat is taken. A plain write passes the decode and done
//   states, plus an echo state per echo byte; ^U reads and checks each erased
//   byte, plus an echo state per echo byte; a read passes a ring read, a wait
//   for the registered ring read port and an emit state for each returned
//   byte. Results go out of one output register; a stalled receiver holds
//   that register and the sequencer waits.
// Reset:
//   Rings need no clearing: fill counts gate every read. Pointers, fills,
//   flags and configuration reset at once; in_ready_o is high as soon as
//   reset is released.
// ----------------------------------------------------------------------------
module terminal_line_discipline_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [6:0]  read_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_byte_o,
  output logic             byte_valid_o,
  output logic             last_of_run_o,
  output logic [2:0]       status_o,
  output logic [1:0]       signal_request_o,
  output logic [15:0]      signal_group_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int unsigned PW = tld_pkg::PtrW;
  localparam int unsigned FW = tld_pkg::FillW;

  tld_pkg::state_e state_q, state_d;
  tld_pkg::ring_req_t req;
  logic [7:0] in_rdata, out_rdata;

  logic echo_q, canon_q;
  logic [15:0] fg_q;
  logic [PW-1:0] irp_q, irp_d, iwp_q, iwp_d, orp_q, orp_d, owp_q, owp_d;
  logic [FW-1:0] ifill_q, ifill_d, ofill_q, ofill_d, nl_q, nl_d;
  logic eof_q, eof_d, mcl_q, mcl_d, scl_q, scl_d;

  logic [2:0] op_q, op_d;
  logic [7:0] dat_q, dat_d;
  logic [6:0] len_q, len_d, cnt_q, cnt_d;
  logic       kill_q, kill_d;
  // echo queue: up to three bytes
  logic [23:0] eq_q, eq_d;
  logic [1:0]  en_q, en_d;

  logic       ov_q, ov_d;
  logic [7:0] ob_q, ob_d;
  logic       obv_q, obv_d, olast_q, olast_d;
  logic [2:0] ost_q, ost_d;
  logic [1:0] osig_q, osig_d;
  logic [15:0] ogrp_q, ogrp_d;

  tld_rings u_rings (
    .clk_i      (clk_i),
    .req_i      (req),
    .in_rdata_o (in_rdata),
    .out_rdata_o(out_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q <= 1'b1;
      canon_q <= 1'b1;
      fg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tld_pkg::CfgEcho:  echo_q <= cfg_data_i[0];
        tld_pkg::CfgCanon: canon_q <= cfg_data_i[0];
        tld_pkg::CfgGroup: fg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tld_pkg::S_IDLE;
      irp_q <= '0; iwp_q <= '0; orp_q <= '0; owp_q <= '0;
      ifill_q <= '0; ofill_q <= '0; nl_q <= '0;
      eof_q <= 1'b0; mcl_q <= 1'b0; scl_q <= 1'b0;
      en_q <= '0; ov_q <= 1'b0; kill_q <= 1'b0; cnt_q <= '0;
    end else begin
      state_q <= state_d;
      irp_q <= irp_d; iwp_q <= iwp_d; orp_q <= orp_d; owp_q <= owp_d;
      ifill_q <= ifill_d; ofill_q <= ofill_d; nl_q <= nl_d;
      eof_q <= eof_d; mcl_q <= mcl_d; scl_q <= scl_d;
      en_q <= en_d; ov_q <= ov_d; kill_q <= kill_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; dat_q <= dat_d; len_q <= len_d; eq_q <= eq_d;
    ob_q <= ob_d; obv_q <= obv_d; olast_q <= olast_d; ost_q <= ost_d;
    osig_q <= osig_d; ogrp_q <= ogrp_d;
  end

  always_comb begin
    logic [7:0] b;
    logic [6:0] lim;
    b = '0;
    lim = '0;
    state_d = state_q;
    irp_d = irp_q; iwp_d = iwp_q; orp_d = orp_q; owp_d = owp_q;
    ifill_d = ifill_q; ofill_d = ofill_q; nl_d = nl_q;
    eof_d = eof_q; mcl_d = mcl_q; scl_d = scl_q;
    op_d = op_q; dat_d = dat_q; len_d = len_q; cnt_d = cnt_q;
    kill_d = kill_q; eq_d = eq_q; en_d = en_q;
    ov_d = ov_q; ob_d = ob_q; obv_d = obv_q; olast_d = olast_q;
    ost_d = ost_q; osig_d = osig_q; ogrp_d = ogrp_q;
    req = '0;
    in_ready_o = 1'b0;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      tld_pkg::S_IDLE: begin
        in_ready_o = !ov_q;
        if (in_valid_i && !ov_q) begin
          op_d = operation_i;
          dat_d = data_byte_i;
          lim = (read_length_i > 7'(tld_pkg::MaxRead)) ? 7'(tld_pkg::MaxRead)
                                                       : read_length_i;
          len_d = lim;
          cnt_d = '0;
          kill_d = 1'b0;
          en_d = '0;
          ob_d = '0; obv_d = 1'b0; olast_d = 1'b1; ost_d = tld_pkg::StOk;
          osig_d = tld_pkg::SigNone; ogrp_d = '0;
          state_d = tld_pkg::S_DECODE;
        end
      end

      tld_pkg::S_DECODE: begin
        state_d = tld_pkg::S_DONE;
        unique case (op_q)
          tld_pkg::OpMasterWrite: begin
            if (scl_q) begin
              ost_d = tld_pkg::StClosed;
            end else if (canon_q && (dat_q == tld_pkg::ChIntr || dat_q == tld_pkg::ChSusp)) begin
              eq_d = {tld_pkg::ChCaret,
                      (dat_q == tld_pkg::ChIntr) ? tld_pkg::ChC : tld_pkg::ChZ,
                      tld_pkg::ChNl};
              en_d = 2'd3;
              if (fg_q != '0) begin
                osig_d = (dat_q == tld_pkg::ChIntr) ? tld_pkg::SigInt : tld_pkg::SigStop;
                ogrp_d = fg_q;
              end
              irp_d = '0; iwp_d = '0; ifill_d = '0; nl_d = '0;
              state_d = tld_pkg::S_ECHO;
            end else if (canon_q && dat_q == tld_pkg::ChEof) begin
              eof_d = 1'b1;
            end else if (canon_q && dat_q == tld_pkg::ChKill) begin
              kill_d = 1'b1;
              state_d = tld_pkg::S_ERASE_RD;
            end else if (canon_q && (dat_q == tld_pkg::ChDel || dat_q == tld_pkg::ChBs)) begin
              state_d = tld_pkg::S_ERASE_RD;
            end else if (ifill_q == FW'(tld_pkg::RingDepth)) begin
              ost_d = tld_pkg::StFull;
            end else begin
              req.in_we = 1'b1;
              req.in_waddr = iwp_q;
              req.in_wdata = dat_q;
              iwp_d = tld_pkg::ptr_inc(iwp_q);
              ifill_d = ifill_q + 1'b1;
              if (dat_q == tld_pkg::ChNl) nl_d = nl_q + 1'b1;
              if (echo_q) begin
                eq_d = {dat_q, 16'h0};
                en_d = 2'd1;
                state_d = tld_pkg::S_ECHO;
              end
            end
          end
          tld_pkg::OpMasterRead: state_d = tld_pkg::S_ORD;
          tld_pkg::OpSlaveWrite: begin
            if (mcl_q) begin
              ost_d = tld_pkg::StClosed;
            end else if (ofill_q == FW'(tld_pkg::RingDepth)) begin
              ost_d = tld_pkg::StFull;
            end else begin
              req.out_we = 1'b1;
              req.out_waddr = owp_q;
              req.out_wdata = dat_q;
              owp_d = tld_pkg::ptr_inc(owp_q);
              ofill_d = ofill_q + 1'b1;
            end
          end
          tld_pkg::OpSlaveRead: begin
            if (canon_q && eof_q && ifill_q == '0) begin
              eof_d = 1'b0;
              ost_d = tld_pkg::StEof;
            end else if (canon_q && nl_q == '0 && !mcl_q && !eof_q) begin
              ost_d = tld_pkg::StNotRdy;
            end else begin
              if (canon_q) eof_d = 1'b0;
              state_d = tld_pkg::S_IRD;
            end
          end
          tld_pkg::OpCloseMaster: mcl_d = 1'b1;
          tld_pkg::OpCloseSlave:  scl_d = 1'b1;
          default: ;
        endcase
      end

      // push one echo byte a cycle, drop when the output ring is full
      tld_pkg::S_ECHO: begin
        if (ofill_q != FW'(tld_pkg::RingDepth)) begin
          req.out_we = 1'b1;
          req.out_waddr = owp_q;
          req.out_wdata = eq_q[23:16];
          owp_d = tld_pkg::ptr_inc(owp_q);
          ofill_d = ofill_q + 1'b1;
        end
        eq_d = {eq_q[15:0], 8'h0};
        en_d = en_q - 1'b1;
        if (en_q == 2'd1) begin
          state_d = kill_q ? tld_pkg::S_ERASE_RD : tld_pkg::S_DONE;
        end
      end

      tld_pkg::S_ERASE_RD: begin
        if (ifill_q == '0) begin
          state_d = tld_pkg::S_DONE;
        end else begin
          iwp_d = tld_pkg::ptr_dec(iwp_q);
          ifill_d = ifill_q - 1'b1;
          req.in_re = 1'b1;
          req.in_raddr = tld_pkg::ptr_dec(iwp_q);
          state_d = tld_pkg::S_ERASE_CHK;
        end
      end

      tld_pkg::S_ERASE_CHK: begin
        if (in_rdata == tld_pkg::ChNl && nl_q != '0) nl_d = nl_q - 1'b1;
        if (echo_q) begin
          eq_d = {tld_pkg::ChBs, tld_pkg::ChSp, tld_pkg::ChBs};
          en_d = 2'd3;
          state_d = tld_pkg::S_ECHO;
        end else begin
          state_d = kill_q ? tld_pkg::S_ERASE_RD : tld_pkg::S_DONE;
        end
      end

      tld_pkg::S_IRD: begin
        if (cnt_q < len_q && ifill_q != '0) begin
          req.in_re = 1'b1;
          req.in_raddr = irp_q;
          irp_d = tld_pkg::ptr_inc(irp_q);
          ifill_d = ifill_q - 1'b1;
          state_d = tld_pkg::S_RDWAIT;
        end else begin
          if (cnt_q == '0) begin
            if (len_q != '0)
              ost_d = (ifill_q == '0 && mcl_q) ? tld_pkg::StClosed : tld_pkg::StNotRdy;
            state_d = tld_pkg::S_DONE;
          end else begin
            // final beat already sent; last flag is on it
            state_d = tld_pkg::S_IDLE;
          end
        end
      end

      tld_pkg::S_ORD: begin
        if (cnt_q < len_q && ofill_q != '0) begin
          req.out_re = 1'b1;
          req.out_raddr = orp_q;
          orp_d = tld_pkg::ptr_inc(orp_q);
          ofill_d = ofill_q - 1'b1;
          state_d = tld_pkg::S_RDWAIT;
        end else if (cnt_q == '0) begin
          if (len_q != '0) ost_d = scl_q ? tld_pkg::StClosed : tld_pkg::StNotRdy;
          state_d = tld_pkg::S_DONE;
        end else begin
          state_d = tld_pkg::S_IDLE;
        end
      end

      tld_pkg::S_RDWAIT: state_d = tld_pkg::S_EMIT;

      // emit one byte beat; decide here whether it is the last
      tld_pkg::S_EMIT: begin
        if (!ov_q) begin
          b = (op_q == tld_pkg::OpMasterRead) ? out_rdata : in_rdata;
          ob_d = b; obv_d = 1'b1; ost_d = tld_pkg::StOk;
          osig_d = tld_pkg::SigNone; ogrp_d = '0;
          cnt_d = cnt_q + 1'b1;
          ov_d = 1'b1;
          if (op_q == tld_pkg::OpMasterRead) begin
            olast_d = (cnt_q + 1'b1 == len_q) || (ofill_q == '0);
            state_d = olast_d ? tld_pkg::S_IDLE : tld_pkg::S_ORD;
          end else begin
            olast_d = (cnt_q + 1'b1 == len_q) || (ifill_q == '0) ||
                      (canon_q && b == tld_pkg::ChNl);
            if (b == tld_pkg::ChNl && nl_q != '0) nl_d = nl_q - 1'b1;
            state_d = olast_d ? tld_pkg::S_IDLE : tld_pkg::S_IRD;
          end
        end
      end

      tld_pkg::S_DONE: begin
        if (!ov_q) begin
          ov_d = 1'b1;
          olast_d = 1'b1;
          state_d = tld_pkg::S_IDLE;
        end
      end

      default: state_d = tld_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o      = ov_q;
  assign read_byte_o      = ob_q;
  assign byte_valid_o     = obv_q;
  assign last_of_run_o    = olast_q;
  assign status_o         = ost_q;
  assign signal_request_o = osig_q;
  assign signal_group_o   = ogrp_q;
endmodule
`default_nettype wire

FILE: rtl/tld_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tld_checker: port-level checks
// Watches handshakes and result fields of the line discipline.
// ----------------------------------------------------------------------------
module tld_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  read_byte_o,
  input wire logic        byte_valid_o,
  input wire logic        last_of_run_o,
  input wire logic [2:0]  status_o,
  input wire logic [1:0]  signal_request_o,
  input wire logic [15:0] signal_group_o
);
  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_byte_o) &&
    $stable(last_of_run_o) && $stable(status_o))
    else $error("result beat changed under stall");

  // a data beat always reports ok and no signal
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> status_o == 3'd0 && signal_request_o == 2'd0)
    else $error("data beat with status or signal");

  // no new item while a result is waiting
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result waits");

  // a signal always carries a nonzero group and is the last of its run
  a_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && signal_request_o != 2'd0 |-> signal_group_o != 16'd0 && last_of_run_o)
    else $error("signal without group");

  // an empty beat is always the last of its run and carries a zero byte
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_of_run_o && read_byte_o == 8'd0)
    else $error("empty beat not last");

  logic unused_in;
  assign unused_in = in_valid_i;
endmodule

bind terminal_line_discipline_top tld_checker u_tld_checker (.*);
`default_nettype wire

FILE: test/tb_terminal_line_discipline_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_line_discipline_top: line discipline self-checking bench
// Drives master/slave operations through the valid/ready port and predicts
// every result beat with a behavioral model of both byte rings, comparing
// each whole result beat as it leaves the block.
// ----------------------------------------------------------------------------
module tb_terminal_line_discipline_top;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic [6:0] len;
  } term_op_t;

  typedef struct packed {
    logic [7:0]  rbyte;
    logic        bvalid;
    logic        last;
    logic [2:0]  status;
    logic [1:0]  sig;
    logic [15:0] grp;
  } term_res_t;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  operation_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [6:0]  read_length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  read_byte_o;
  logic        byte_valid_o;
  logic        last_of_run_o;
  logic [2:0]  status_o;
  logic [1:0]  signal_request_o;
  logic [15:0] signal_group_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  terminal_line_discipline_top i_dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  kbd_ring [tld_pkg::RingDepth];
  logic [7:0]  scr_ring [tld_pkg::RingDepth];
  int unsigned kbd_rd, kbd_wr, kbd_fill, scr_rd, scr_wr, scr_fill, lines;
  bit          eof_seen, mst_closed, slv_closed;
  bit          echo_on, canon_on;
  logic [15:0] fg_group;

  term_op_t    pending_ops[$];
  term_res_t   expected_results[$];
  int unsigned mismatches = 0, results_seen = 0, beats_sent = 0, cycles = 0;
  bit          quiet = 1'b0;
  int          in_gap = 0, out_gap = 0;

  function automatic void screen_push(logic [7:0] b);
    if (scr_fill < tld_pkg::RingDepth) begin
      scr_ring[scr_wr] = b;
      scr_wr = (scr_wr + 1) % tld_pkg::RingDepth;
      scr_fill++;
    end
  endfunction

  function automatic void add_result(logic [7:0] b, logic v, logic [2:0] st,
                                     logic [1:0] sg, logic [15:0] g);
    term_res_t r;
    r = '{rbyte: b, bvalid: v, last: 1'b0, status: st, sig: sg, grp: g};
    expected_results.push_back(r);
  endfunction

  function automatic void rub_out();
    kbd_wr = (kbd_wr == 0) ? tld_pkg::RingDepth - 1 : kbd_wr - 1;
    kbd_fill--;
    if (kbd_ring[kbd_wr] == tld_pkg::ChNl && lines > 0) lines--;
    if (echo_on) begin
      screen_push(tld_pkg::ChBs);
      screen_push(tld_pkg::ChSp);
      screen_push(tld_pkg::ChBs);
    end
  endfunction

  function automatic logic [7:0] kbd_pop();
    logic [7:0] b;
    b = kbd_ring[kbd_rd];
    kbd_rd = (kbd_rd + 1) % tld_pkg::RingDepth;
    kbd_fill--;
    if (b == tld_pkg::ChNl && lines > 0) lines--;
    return b;
  endfunction

  function automatic void predict_op(term_op_t t);
    int unsigned n, len, base_count;
    logic [7:0]  b;
    logic [2:0]  st;
    n = 0;
    len = (t.len > tld_pkg::MaxRead) ? tld_pkg::MaxRead : t.len;
    base_count = expected_results.size();
    case (t.op)
      tld_pkg::OpMasterWrite: begin
        st = tld_pkg::StOk;
        if (slv_closed) begin
          st = tld_pkg::StClosed;
        end else if (canon_on && (t.data == tld_pkg::ChIntr ||
                                  t.data == tld_pkg::ChSusp)) begin
          screen_push(tld_pkg::ChCaret);
          screen_push(t.data == tld_pkg::ChIntr ? tld_pkg::ChC : tld_pkg::ChZ);
          screen_push(tld_pkg::ChNl);
          kbd_rd = 0; kbd_wr = 0; kbd_fill = 0; lines = 0;
          if (fg_group != 0) begin
            add_result(8'h00, 1'b0, tld_pkg::StOk,
                       t.data == tld_pkg::ChIntr ? tld_pkg::SigInt : tld_pkg::SigStop,
                       fg_group);
            n = 1;
          end
        end else if (canon_on && t.data == tld_pkg::ChEof) begin
          eof_seen = 1'b1;
        end else if (canon_on && t.data == tld_pkg::ChKill) begin
          while (kbd_fill > 0) rub_out();
        end else if (canon_on && (t.data == tld_pkg::ChDel || t.data == tld_pkg::ChBs)) begin
          if (kbd_fill > 0) rub_out();
        end else if (kbd_fill >= tld_pkg::RingDepth) begin
          st = tld_pkg::StFull;
        end else begin
          kbd_ring[kbd_wr] = t.data;
          kbd_wr = (kbd_wr + 1) % tld_pkg::RingDepth;
          kbd_fill++;
          if (t.data == tld_pkg::ChNl) lines++;
          if (echo_on) screen_push(t.data);
        end
        if (n == 0) add_result(8'h00, 1'b0, st, tld_pkg::SigNone, 16'h0);
      end
      tld_pkg::OpMasterRead: begin
        while (n < len && scr_fill > 0) begin
          add_result(scr_ring[scr_rd], 1'b1, tld_pkg::StOk, tld_pkg::SigNone, 16'h0);
          scr_rd = (scr_rd + 1) % tld_pkg::RingDepth;
          scr_fill--;
          n++;
        end
        if (n == 0)
          add_result(8'h00, 1'b0, len == 0 ? tld_pkg::StOk :
                     (slv_closed ? tld_pkg::StClosed : tld_pkg::StNotRdy),
                     tld_pkg::SigNone, 16'h0);
      end
      tld_pkg::OpSlaveWrite: begin
        if (mst_closed)
          add_result(8'h00, 1'b0, tld_pkg::StClosed, tld_pkg::SigNone, 16'h0);
        else if (scr_fill >= tld_pkg::RingDepth)
          add_result(8'h00, 1'b0, tld_pkg::StFull, tld_pkg::SigNone, 16'h0);
        else begin
          screen_push(t.data);
          add_result(8'h00, 1'b0, tld_pkg::StOk, tld_pkg::SigNone, 16'h0);
        end
      end
      tld_pkg::OpSlaveRead: begin
        if (canon_on && eof_seen && kbd_fill == 0) begin
          eof_seen = 1'b0;
          add_result(8'h00, 1'b0, tld_pkg::StEof, tld_pkg::SigNone, 16'h0);
        end else if (canon_on && lines == 0 && !mst_closed && !eof_seen) begin
          add_result(8'h00, 1'b0, tld_pkg::StNotRdy, tld_pkg::SigNone, 16'h0);
        end else begin
          if (canon_on) eof_seen = 1'b0;
          while (n < len && kbd_fill > 0) begin
            b = kbd_pop();
            add_result(b, 1'b1, tld_pkg::StOk, tld_pkg::SigNone, 16'h0);
            n++;
            if (canon_on && b == tld_pkg::ChNl) break;
          end
          if (n == 0)
            add_result(8'h00, 1'b0, len == 0 ? tld_pkg::StOk :
                       ((kbd_fill == 0 && mst_closed) ? tld_pkg::StClosed
                                                      : tld_pkg::StNotRdy),
                       tld_pkg::SigNone, 16'h0);
        end
      end
      tld_pkg::OpCloseMaster: begin
        mst_closed = 1'b1;
        add_result(8'h00, 1'b0, tld_pkg::StOk, tld_pkg::SigNone, 16'h0);
      end
      tld_pkg::OpCloseSlave: begin
        slv_closed = 1'b1;
        add_result(8'h00, 1'b0, tld_pkg::StOk, tld_pkg::SigNone, 16'h0);
      end
      default: add_result(8'h00, 1'b0, tld_pkg::StOk, tld_pkg::SigNone, 16'h0);
    endcase
    expected_results[expected_results.size() - 1].last = 1'b1;
    if (expected_results.size() == base_count) $display("tb: predictor produced no beat");
  endfunction

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_valid_i && in_ready_o) begin
      predict_op({operation_i, data_byte_i, read_length_i});
      beats_sent <= beats_sent + 1;
    end
    if (!in_valid_i || in_ready_o) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(1, 6) - 1;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        {operation_i, data_byte_i, read_length_i} <= pending_ops.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(1, 6) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    term_res_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{rbyte: read_byte_o, bvalid: byte_valid_o, last: last_of_run_o,
              status: status_o, sig: signal_request_o, grp: signal_group_o};
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected beat %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("tb: mismatch expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic add_op(int op, int d, int l);
    pending_ops.push_back('{op: 3'(op), data: 8'(d), len: 7'(l)});
  endtask

  // sample between edges so the driver's updates have settled
  task automatic drain();
    while (pending_ops.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tld_pkg::CfgEcho:  echo_on = val[0];
      tld_pkg::CfgCanon: canon_on = val[0];
      default:           fg_group = val;
    endcase
    @(posedge clk_i);
  endtask

  // a typed line with optional editing and slave writes, then reads on both sides
  task automatic add_session();
    int k;
    k = $urandom_range(1, 8);
    repeat (k) begin
      case ($urandom_range(0, 9))
        0: add_op(tld_pkg::OpMasterWrite, tld_pkg::ChBs, 0);
        1: add_op(tld_pkg::OpMasterWrite, tld_pkg::ChDel, 0);
        2: add_op(tld_pkg::OpSlaveWrite, $urandom, 0);
        default: add_op(tld_pkg::OpMasterWrite, $urandom_range(8'h20, 8'hFF), 0);
      endcase
    end
    case ($urandom_range(0, 9))
      0: add_op(tld_pkg::OpMasterWrite, tld_pkg::ChKill, 0);
      1: add_op(tld_pkg::OpMasterWrite, tld_pkg::ChIntr, 0);
      2: add_op(tld_pkg::OpMasterWrite, tld_pkg::ChSusp, 0);
      3: add_op(tld_pkg::OpMasterWrite, tld_pkg::ChEof, 0);
      4: add_op(tld_pkg::OpMasterWrite, $urandom, 0);
      default: add_op(tld_pkg::OpMasterWrite, tld_pkg::ChNl, 0);
    endcase
    add_op(tld_pkg::OpSlaveRead, 0, $urandom_range(0, 127));
    add_op(tld_pkg::OpMasterRead, 0, $urandom_range(0, 127));
  endtask

  task automatic add_noise(int count);
    repeat (count) add_op($urandom_range(0, 7), $urandom, $urandom);
  endtask

  initial begin
    kbd_rd = 0; kbd_wr = 0; kbd_fill = 0; scr_rd = 0; scr_wr = 0; scr_fill = 0;
    lines = 0; eof_seen = 0; mst_closed = 0; slv_closed = 0;
    echo_on = 1; canon_on = 1; fg_group = 16'h0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: control chars with no group, editing, eof, length extremes
    add_op(tld_pkg::OpMasterRead, 0, 5);
    add_op(tld_pkg::OpSlaveRead, 0, 5);
    add_op(tld_pkg::OpSlaveRead, 0, 0);
    add_op(tld_pkg::OpMasterWrite, 8'h00, 0);
    add_op(tld_pkg::OpMasterWrite, 8'hFF, 0);
    add_op(tld_pkg::OpMasterWrite, tld_pkg::ChBs, 0);
    add_op(tld_pkg::OpMasterWrite, tld_pkg::ChNl, 0);
    add_op(tld_pkg::OpMasterWrite, tld_pkg::ChDel, 0);
    add_op(tld_pkg::OpMasterWrite, 8'h41, 0);
    add_op(tld_pkg::OpMasterWrite, tld_pkg::ChKill, 0);
    add_op(tld_pkg::OpMasterWrite, tld_pkg::ChBs, 0);
    add_op(tld_pkg::OpMasterWrite, tld_pkg::ChIntr, 0);
    add_op(tld_pkg::OpMasterWrite, tld_pkg::ChSusp, 0);
    add_op(tld_pkg::OpMasterWrite, tld_pkg::ChEof, 0);
    add_op(tld_pkg::OpSlaveRead, 0, 64);
    add_op(tld_pkg::OpSlaveWrite, 8'hA5, 0);
    add_op(tld_pkg::OpMasterRead, 0, 127);
    add_op(tld_pkg::OpMasterRead, 0, 0);
    add_op(6, 8'h55, 1);
    add_op(7, 8'hAA, 2);
    drain();

    write_reg(tld_pkg::CfgGroup, 16'hFFFF);
    write_reg(tld_pkg::CfgEcho, 16'h0);
    add_op(tld_pkg::OpMasterWrite, 8'h31, 0);
    add_op(tld_pkg::OpMasterWrite, tld_pkg::ChIntr, 0);
    add_op(tld_pkg::OpMasterWrite, 8'h32, 0);
    add_op(tld_pkg::OpMasterWrite, tld_pkg::ChSusp, 0);
    add_op(tld_pkg::OpMasterRead, 0, 64);
    repeat (4) add_session();
    drain();

    write_reg(tld_pkg::CfgEcho, 16'h1);
    write_reg(tld_pkg::CfgCanon, 16'h0);
    repeat (3) add_session();
    add_noise(6);
    drain();

    write_reg(tld_pkg::CfgCanon, 16'h1);
    write_reg(tld_pkg::CfgGroup, 16'($urandom));
    repeat (3) add_session();
    add_noise(5);
    drain();

    // closing, last part without idling
    quiet = 1'b1;
    add_op(tld_pkg::OpMasterWrite, 8'h61, 0);
    add_op(tld_pkg::OpCloseMaster, 0, 0);
    add_op(tld_pkg::OpSlaveWrite, 8'h62, 0);
    add_op(tld_pkg::OpSlaveRead, 0, 10);
    add_op(tld_pkg::OpSlaveRead, 0, 10);
    add_op(tld_pkg::OpCloseSlave, 0, 0);
    add_op(tld_pkg::OpMasterWrite, 8'h63, 0);
    add_op(tld_pkg::OpMasterRead, 0, 64);
    add_op(tld_pkg::OpMasterRead, 0, 64);
    add_op(tld_pkg::OpCloseMaster, 0, 0);
    add_noise(5);
    drain();

    $display("tb: %0d operations sent, %0d result beats checked", beats_sent,
             results_seen);
    $display("tb: covered echo/canonical modes, control chars, editing, reads, closes");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("tb: timeout");
    $display("tb: failure");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/tld_pkg.sv
rtl/tld_rings.sv
rtl/terminal_line_discipline_top.sv
rtl/tld_checker.sv
test/tb_terminal_line_discipline_top.sv
